// File: hdl/mlcr_pkg.sv
package mlcr_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int COLOR_BITS = 4;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_STEP    = 2'd1,
        FUNC_RESOLVE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PIXEL = 2'd1,
        KIND_PAINT = 2'd2
    } kind_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKGROUND = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTSIDE    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INSIDE     = 2'd2;

    localparam logic [COLOR_BITS-1:0] BACKGROUND_RESET = 4'd10;
    localparam logic [COLOR_BITS-1:0] OUTSIDE_RESET    = 4'd14;
    localparam logic [COLOR_BITS-1:0] INSIDE_RESET     = 4'd0;

endpackage

// File: hdl/midpoint_line_clip_rasterizer_core.sv
// Midpoint line rasterizer with color-region clipping. A load request
// (s_tuser = 0) takes two endpoints and orders them so the walk runs upward
// in y or along the major axis; each step request (s_tuser = 1) returns the
// next pixel (the start pixel is never returned), with m_tlast on the final
// pixel and a done flag once nothing is left; a resolve request
// (s_tuser = 2) turns the framebuffer color read at that pixel into the
// paint color. Code 3 is dropped without a result. Every other request gives
// exactly one result, through the input register and then the result
// register. One request is taken every clock unless m_tready stalls the
// output: a step's decision update is a single add and compare; it writes
// the line state at the same edge that the next request enters the compute
// stage. Color registers are written through the always-ready cfg port.
module midpoint_line_clip_rasterizer_core
    import mlcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int IN_W  = ((4*COORD_BITS + COLOR_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2*COORD_BITS + COLOR_BITS + 1 + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // x_start, y_start, x_end, y_end, read_color (low bit up)
    input  logic [IN_W-1:0]           s_tdata,
    // func
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pixel_x, pixel_y, paint_color, done_res (low bit up)
    output logic [OUT_W-1:0]          m_tdata,
    // kind
    output logic [1:0]                m_tuser,
    // last
    output logic                      m_tlast,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COLOR_BITS-1:0]     cfg_data
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 2;
    localparam int OUT_USED = 2*CB + COLOR_BITS + 1;

    // input stage
    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic [1:0]        in_func_reg;

    // result stage
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;
    logic              out_fire_next;

    // color registers
    logic [COLOR_BITS-1:0] background_reg, outside_reg, inside_reg;

    // line state
    logic signed [CB-1:0] cur_x_reg, cur_x_next;
    logic signed [CB-1:0] cur_y_reg, cur_y_next;
    logic signed [CB-1:0] stop_reg, stop_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic [CB-1:0]        delta_x_reg, delta_x_next;
    logic [CB-1:0]        delta_y_reg, delta_y_next;
    logic                 x_major_reg, x_major_next;
    logic                 neg_reg, neg_next;
    logic                 active_reg, active_next;

    logic out_free, advance;

    // load datapath
    logic signed [CB-1:0] xa, ya, xb, yb;
    logic signed [CB:0]   ddx, ddy;
    logic [CB:0]          adx_w, ady_w;
    logic [CB-1:0]        adx, ady;
    logic                 ld_neg, ld_swap, ld_xmaj;
    logic signed [DW-1:0] ax_e, ay_e, hx_e, hy_e;
    logic [COLOR_BITS-1:0] rd_color;

    // step datapath
    logic signed [DW-1:0] dx_e, dy_e;
    logic                 at_stop, minor;
    logic signed [CB-1:0] new_major;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign xa = in_data_reg[CB-1:0];
    assign ya = in_data_reg[2*CB-1:CB];
    assign xb = in_data_reg[3*CB-1:2*CB];
    assign yb = in_data_reg[4*CB-1:3*CB];
    assign rd_color = in_data_reg[4*CB +: COLOR_BITS];

    assign ddx = {xb[CB-1], xb} - {xa[CB-1], xa};
    assign ddy = {yb[CB-1], yb} - {ya[CB-1], ya};
    assign adx_w = ddx[CB] ? -ddx : ddx;
    assign ady_w = ddy[CB] ? -ddy : ddy;
    assign adx = adx_w[CB-1:0];
    assign ady = ady_w[CB-1:0];
    assign ld_neg = (!ddx[CB] && (ddx != '0) && ddy[CB])
                 || (ddx[CB] && !ddy[CB] && (ddy != '0));
    assign ld_swap = ld_neg ? (xa < xb) : ((xa > xb) || ((ddx == '0) && (ya > yb)));
    assign ld_xmaj = adx > ady;
    assign ax_e = signed'({2'b00, adx});
    assign ay_e = signed'({2'b00, ady});
    assign hx_e = signed'({3'b000, adx[CB-1:1]});
    assign hy_e = signed'({3'b000, ady[CB-1:1]});

    assign dx_e = signed'({2'b00, delta_x_reg});
    assign dy_e = signed'({2'b00, delta_y_reg});
    assign at_stop = (x_major_reg ? cur_x_reg : cur_y_reg) == stop_reg;

    always_comb begin
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        stop_next     = stop_reg;
        decision_next = decision_reg;
        delta_x_next  = delta_x_reg;
        delta_y_next  = delta_y_reg;
        x_major_next  = x_major_reg;
        neg_next      = neg_reg;
        active_next   = active_reg;
        out_data_next = '0;
        out_kind_next = KIND_LOAD;
        out_last_next = 1'b0;
        out_fire_next = 1'b1;
        minor         = 1'b0;
        new_major     = '0;
        unique case (in_func_reg)
            FUNC_LOAD: begin
                x_major_next = ld_xmaj;
                neg_next     = ld_neg;
                delta_x_next = adx;
                delta_y_next = ady;
                cur_x_next   = ld_swap ? xb : xa;
                cur_y_next   = ld_swap ? yb : ya;
                stop_next    = ld_xmaj ? (ld_swap ? xa : xb) : (ld_swap ? ya : yb);
                if (ld_xmaj) begin
                    decision_next = ld_neg ? (hx_e - ay_e) : (ay_e - hx_e);
                end else begin
                    decision_next = ld_neg ? (ax_e - hy_e) : (hy_e - ax_e);
                end
                active_next = 1'b1;
            end
            FUNC_STEP: begin
                out_kind_next = KIND_PIXEL;
                if (!active_reg || at_stop) begin
                    active_next = 1'b0;
                    out_data_next[OUT_USED-1] = 1'b1;
                end else begin
                    if (x_major_reg) begin
                        if (!neg_reg) begin
                            cur_x_next    = cur_x_reg + 1'b1;
                            minor         = !decision_reg[DW-1];
                            decision_next = decision_reg + (minor ? (dy_e - dx_e) : dy_e);
                        end else begin
                            cur_x_next    = cur_x_reg - 1'b1;
                            minor         = decision_reg[DW-1] || (decision_reg == '0);
                            decision_next = decision_reg + (minor ? (dx_e - dy_e) : -dy_e);
                        end
                        if (minor && (delta_y_reg != '0)) begin
                            cur_y_next = cur_y_reg + 1'b1;
                        end
                        new_major = cur_x_next;
                    end else begin
                        cur_y_next = cur_y_reg + 1'b1;
                        if (!neg_reg) begin
                            minor         = decision_reg[DW-1] || (decision_reg == '0);
                            decision_next = decision_reg + (minor ? (dy_e - dx_e) : -dx_e);
                            if (minor && (delta_x_reg != '0)) begin
                                cur_x_next = cur_x_reg + 1'b1;
                            end
                        end else begin
                            minor         = !decision_reg[DW-1];
                            decision_next = decision_reg + (minor ? (dx_e - dy_e) : dx_e);
                            if (minor && (delta_x_reg != '0)) begin
                                cur_x_next = cur_x_reg - 1'b1;
                            end
                        end
                        new_major = cur_y_next;
                    end
                    out_data_next[CB-1:0]    = cur_x_next;
                    out_data_next[2*CB-1:CB] = cur_y_next;
                    if (new_major == stop_reg) begin
                        out_last_next = 1'b1;
                        active_next   = 1'b0;
                    end
                end
            end
            FUNC_RESOLVE: begin
                out_kind_next = KIND_PAINT;
                out_data_next[2*CB +: COLOR_BITS] =
                    (rd_color == background_reg) ? inside_reg : outside_reg;
            end
            default: begin
                // unused code: drop silently
                out_fire_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            background_reg <= BACKGROUND_RESET;
            outside_reg    <= OUTSIDE_RESET;
            inside_reg     <= INSIDE_RESET;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            stop_reg       <= '0;
            decision_reg   <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            x_major_reg    <= 1'b0;
            neg_reg        <= 1'b0;
            active_reg     <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                cur_x_reg    <= cur_x_next;
                cur_y_reg    <= cur_y_next;
                stop_reg     <= stop_next;
                decision_reg <= decision_next;
                delta_x_reg  <= delta_x_next;
                delta_y_reg  <= delta_y_next;
                x_major_reg  <= x_major_next;
                neg_reg      <= neg_next;
                active_reg   <= active_next;
            end
            if (out_free) begin
                out_valid_reg <= advance && out_fire_next;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_BACKGROUND) begin
                    background_reg <= cfg_data;
                end else if (cfg_index == CFG_OUTSIDE) begin
                    outside_reg <= cfg_data;
                end else if (cfg_index == CFG_INSIDE) begin
                    inside_reg <= cfg_data;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_func_reg <= s_tuser;
        end
        if (advance && out_fire_next) begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

// File: hdl/mlcr_checker.sv
module mlcr_checker
    import mlcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    localparam int OUT_W = ((2*COORD_BITS + COLOR_BITS + 1 + 7) / 8) * 8
) (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_W-1:0]          m_tdata,
    input logic [1:0]                m_tuser,
    input logic                      m_tlast
);

    localparam int CB = COORD_BITS;
    localparam int DONE_BIT = 2*CB + COLOR_BITS;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // last pixel is a real pixel, never a done marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_PIXEL && !m_tdata[DONE_BIT])
        else $error("last flag on a non-pixel result");

    // done result carries no coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DONE_BIT] |-> m_tuser == KIND_PIXEL
            && m_tdata[2*CB-1:0] == '0 && !m_tlast)
        else $error("done result with coordinates");

    // paint and load results carry no coordinates or flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_PAINT || m_tuser == KIND_LOAD)
            |-> m_tdata[2*CB-1:0] == '0 && !m_tdata[DONE_BIT] && !m_tlast)
        else $error("paint or load result with pixel fields");

endmodule

bind midpoint_line_clip_rasterizer_core mlcr_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
